>>> hdl/mae_pkg.sv
// Shared types and codes for the matrix arithmetic engine.
// Used by every module in hdl/ other than mae_fifo; depends on nothing.
package mae_pkg;

  // Operation selected by the operation register
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_NEG = 2'd2,
    OP_TRN = 2'd3
  } op_e;

  // Command codes of an input word
  localparam logic [1:0] CMD_WR_A = 2'd0;
  localparam logic [1:0] CMD_WR_B = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Status codes of a result word
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DIM = 2'd1;
  localparam logic [1:0] ST_IDX = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_OPERATION = 3'd0;
  localparam logic [2:0] REG_ROWS_A    = 3'd1;
  localparam logic [2:0] REG_COLS_A    = 3'd2;
  localparam logic [2:0] REG_ROWS_B    = 3'd3;
  localparam logic [2:0] REG_COLS_B    = 3'd4;

  localparam int unsigned CFG_DATA_W = 5;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    op_e        operation;
    logic [4:0] rows_a;
    logic [4:0] cols_a;
    logic [4:0] rows_b;
    logic [4:0] cols_b;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    logic [1:0]  status;
  } job_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_e;

  // Clamp a size register to the store dimension
  function automatic logic [4:0] eff_dim(logic [4:0] d, int unsigned lim);
    logic [4:0] r;
    r = (int'(d) > int'(lim)) ? 5'(lim) : d;
    return r;
  endfunction

endpackage

>>> hdl/matrix_arith_engine.sv
// Integer matrix engine: write commands fill stores A and B element by element
// and a read command returns one element of A+B, A times B, -A or the
// transpose of A, in wrapping 32-bit arithmetic, with a status for a size
// mismatch or an index outside the result. A read that ends in an error
// status is answered without evaluation. A multiply read is carried out by
// the single multiply-accumulate unit, which steps through one element of the
// row of A and the column of B per cycle over one read port on each store.
// Commands wait in a four-word queue between the front end and the back end,
// and results wait in a two-word queue.
// Depends on mae_pkg, mae_fifo, mae_front and mae_back.
module matrix_arith_engine #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  mae_pkg::in_word_t    item,
  output logic                 empty,
  input  logic                 pop,
  output mae_pkg::out_word_t   result,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [mae_pkg::CFG_DATA_W-1:0] cfg_data
);

  mae_pkg::cfg_t      cfg;
  mae_pkg::job_t      job_in;
  mae_pkg::job_t      job_out;
  mae_pkg::out_word_t res_in;
  logic               job_push;
  logic               job_full;
  logic               job_pop;
  logic               job_empty;
  logic               res_push;
  logic               res_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.operation <= mae_pkg::OP_ADD;
      cfg.rows_a    <= 5'd1;
      cfg.cols_a    <= 5'd1;
      cfg.rows_b    <= 5'd1;
      cfg.cols_b    <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        mae_pkg::REG_OPERATION: cfg.operation <= mae_pkg::op_e'(cfg_data[1:0]);
        mae_pkg::REG_ROWS_A:    cfg.rows_a    <= cfg_data;
        mae_pkg::REG_COLS_A:    cfg.cols_a    <= cfg_data;
        mae_pkg::REG_ROWS_B:    cfg.rows_b    <= cfg_data;
        mae_pkg::REG_COLS_B:    cfg.cols_b    <= cfg_data;
        default:                cfg.operation <= cfg.operation;
      endcase
    end
  end

  mae_front #(.MAX_DIM(MAX_DIM)) u_front (
    .push     (push),
    .item     (item),
    .full     (full),
    .cfg      (cfg),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  mae_fifo #(.W($bits(mae_pkg::job_t)), .DEPTH(4)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  mae_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_in)
  );

  mae_fifo #(.W($bits(mae_pkg::out_word_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

>>> hdl/mae_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on nothing; DEPTH must be a power of two.
module mae_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (!do_push && do_pop) count <= count - CW'(1);
    end
  end

  // Hold the stored words
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

endmodule

>>> hdl/mae_front.sv
// Front end: accepts input words, drops the ones with no effect and tags reads
// with their status. Depends on mae_pkg.
module mae_front #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic              push,
  input  mae_pkg::in_word_t item,
  output logic              full,
  input  mae_pkg::cfg_t     cfg,
  input  logic              job_full,
  output logic              job_push,
  output mae_pkg::job_t     job
);

  logic [4:0] ra, ca, rb, cb;
  logic [4:0] res_r, res_c;
  logic       dim_bad;
  logic       in_store;
  logic       keep;
  logic [1:0] status;

  assign ra = mae_pkg::eff_dim(cfg.rows_a, MAX_DIM);
  assign ca = mae_pkg::eff_dim(cfg.cols_a, MAX_DIM);
  assign rb = mae_pkg::eff_dim(cfg.rows_b, MAX_DIM);
  assign cb = mae_pkg::eff_dim(cfg.cols_b, MAX_DIM);

  // Result size and dimension check for the configured operation
  always_comb begin
    res_r   = ra;
    res_c   = ca;
    dim_bad = 1'b0;
    case (cfg.operation)
      mae_pkg::OP_ADD: dim_bad = (ra != rb) || (ca != cb);
      mae_pkg::OP_MUL: begin
        res_c   = cb;
        dim_bad = (ca != rb);
      end
      mae_pkg::OP_NEG: dim_bad = 1'b0;
      mae_pkg::OP_TRN: begin
        res_r = ca;
        res_c = ra;
      end
      default: dim_bad = 1'b0;
    endcase
  end

  // Classify the read status
  always_comb begin
    if (dim_bad) begin
      status = mae_pkg::ST_DIM;
    end else if ({1'b0, item.row} >= res_r || {1'b0, item.col} >= res_c) begin
      status = mae_pkg::ST_IDX;
    end else begin
      status = mae_pkg::ST_OK;
    end
  end

  // Writes outside the store and unused commands are dropped here
  assign in_store = (int'(item.row) < int'(MAX_DIM)) && (int'(item.col) < int'(MAX_DIM));
  assign keep = (item.command == mae_pkg::CMD_READ) ||
                (((item.command == mae_pkg::CMD_WR_A) ||
                  (item.command == mae_pkg::CMD_WR_B)) && in_store);

  assign full     = job_full;
  assign job_push = push && !job_full && keep;

  always_comb begin
    job.kind   = item.command;
    job.row    = item.row;
    job.col    = item.col;
    job.value  = item.value;
    job.status = status;
  end

endmodule

>>> hdl/mae_back.sv
// Back end: holds stores A and B, carries out writes and evaluates read words
// with a pipelined multiply-accumulate. Depends on mae_pkg.
module mae_back #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  mae_pkg::cfg_t      cfg,
  input  logic               job_empty,
  input  mae_pkg::job_t      job,
  output logic               job_pop,
  input  logic               res_full,
  output logic               res_push,
  output mae_pkg::out_word_t res_word
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [31:0] store_a [DEPTH];
  logic [31:0] store_b [DEPTH];

  mae_pkg::back_state_e state, state_next;

  logic [3:0]  cur_row;
  logic [3:0]  cur_col;
  logic [4:0]  k;
  logic [4:0]  n_steps;
  logic        issue;
  logic        rd_valid;
  logic        term_valid;
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic [31:0] term;
  logic [31:0] term_next;
  logic [31:0] acc;
  logic        done;
  logic        start;
  logic        wr_a_en;
  logic        wr_b_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic        is_write;

  function automatic logic [AW-1:0] addr(logic [4:0] r, logic [4:0] c);
    logic [31:0] a;
    a = 32'(r) * 32'(MAX_DIM) + 32'(c);
    return a[AW-1:0];
  endfunction

  assign n_steps = (cfg.operation == mae_pkg::OP_MUL) ?
                   mae_pkg::eff_dim(cfg.cols_a, MAX_DIM) : 5'd1;
  assign issue = (state == mae_pkg::BK_RUN) && (k < n_steps);
  assign done  = (state == mae_pkg::BK_RUN) && !issue && !rd_valid && !term_valid;
  assign is_write = (job.kind == mae_pkg::CMD_WR_A) || (job.kind == mae_pkg::CMD_WR_B);
  assign start = (state == mae_pkg::BK_IDLE) && !job_empty &&
                 (job.kind == mae_pkg::CMD_READ) && !res_full &&
                 (job.status == mae_pkg::ST_OK);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mae_pkg::BK_IDLE: if (start) state_next = mae_pkg::BK_RUN;
      mae_pkg::BK_RUN:  if (done)  state_next = mae_pkg::BK_IDLE;
      default:          state_next = mae_pkg::BK_IDLE;
    endcase
  end

  // Outputs: queue handshakes, store writes, result word
  always_comb begin
    job_pop  = 1'b0;
    res_push = 1'b0;
    res_word.result_value = '0;
    res_word.status       = mae_pkg::ST_OK;
    wr_a_en  = 1'b0;
    wr_b_en  = 1'b0;
    case (state)
      mae_pkg::BK_IDLE: begin
        if (!job_empty) begin
          if (is_write) begin
            job_pop = 1'b1;
            wr_a_en = (job.kind == mae_pkg::CMD_WR_A);
            wr_b_en = (job.kind == mae_pkg::CMD_WR_B);
          end else if (!res_full) begin
            job_pop = 1'b1;
            if (job.status != mae_pkg::ST_OK) begin
              res_push        = 1'b1;
              res_word.status = job.status;
            end
          end
        end
      end
      mae_pkg::BK_RUN: begin
        if (done) begin
          res_push              = 1'b1;
          res_word.result_value = acc;
        end
      end
      default: job_pop = 1'b0;
    endcase
  end

  // Read addresses for the current step
  always_comb begin
    rd_addr_a = addr({1'b0, cur_row}, {1'b0, cur_col});
    rd_addr_b = addr({1'b0, cur_row}, {1'b0, cur_col});
    case (cfg.operation)
      mae_pkg::OP_MUL: begin
        rd_addr_a = addr({1'b0, cur_row}, k);
        rd_addr_b = addr(k, {1'b0, cur_col});
      end
      mae_pkg::OP_TRN: rd_addr_a = addr({1'b0, cur_col}, {1'b0, cur_row});
      default:         rd_addr_b = addr({1'b0, cur_row}, {1'b0, cur_col});
    endcase
  end

  assign wr_addr = addr({1'b0, job.row}, {1'b0, job.col});

  // Stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_a_en) store_a[wr_addr] <= job.value;
    if (wr_b_en) store_b[wr_addr] <= job.value;
    rd_a <= store_a[rd_addr_a];
    rd_b <= store_b[rd_addr_b];
  end

  // Per-operation term from the two store words
  always_comb begin
    case (cfg.operation)
      mae_pkg::OP_ADD: term_next = rd_a + rd_b;
      mae_pkg::OP_MUL: term_next = 32'(rd_a * rd_b);
      mae_pkg::OP_NEG: term_next = 32'd0 - rd_a;
      mae_pkg::OP_TRN: term_next = rd_a;
      default:         term_next = rd_a;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mae_pkg::BK_IDLE;
      rd_valid   <= 1'b0;
      term_valid <= 1'b0;
    end else begin
      state      <= state_next;
      rd_valid   <= issue;
      term_valid <= rd_valid;
    end
  end

  // Step counter, term and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      cur_row <= job.row;
      cur_col <= job.col;
      k       <= '0;
      acc     <= '0;
    end else begin
      if (issue)      k   <= k + 5'd1;
      if (term_valid) acc <= acc + term;
    end
    term <= term_next;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_term_follows_read: assert property (@(posedge clk) disable iff (rst)
    term_valid |-> $past(rd_valid))
    else $error("term without a store read");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == mae_pkg::BK_RUN) && (k == 5'd0))
    else $error("read did not start its evaluation");

  a_no_pop_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == mae_pkg::BK_RUN) |-> !job_pop)
    else $error("command taken while a read is in progress");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mae_pkg::BK_RUN) |-> (k <= n_steps))
    else $error("step counter ran past the dot-product length");

endmodule

>>> tb/mae_tb_pkg.sv
`timescale 1ns / 1ps
// Mirror of the matrix engine's stores and registers, kept by the testbench.
// Predicts every read word and checks result words in order; depends on mae_pkg.
package mae_tb_pkg;
  import mae_pkg::*;

  localparam int unsigned DIM         = 16;
  localparam int unsigned MAX_REPORTS = 10;

  class engine_mirror;
    logic [31:0] store_a [DIM*DIM];
    logic [31:0] store_b [DIM*DIM];
    bit          written_a [DIM*DIM];
    bit          written_b [DIM*DIM];
    op_e         op;
    logic [4:0]  rows_a;
    logic [4:0]  cols_a;
    logic [4:0]  rows_b;
    logic [4:0]  cols_b;
    out_word_t   pending_results [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned reads_ok;
    int unsigned reads_err;
    int unsigned words_in;

    function new();
      op           = OP_ADD;
      rows_a       = 5'd1;
      cols_a       = 5'd1;
      rows_b       = 5'd1;
      cols_b       = 5'd1;
      mismatches   = 0;
      results_seen = 0;
      reads_ok     = 0;
      reads_err    = 0;
      words_in     = 0;
      foreach (written_a[i]) begin
        written_a[i] = 1'b0;
        written_b[i] = 1'b0;
      end
    endfunction

    // Clamp a size register to the store dimension
    function logic [4:0] fit_dim(logic [4:0] d);
      return (d > 5'(DIM)) ? 5'(DIM) : d;
    endfunction

    function void write_config(logic [2:0] idx, logic [4:0] data);
      case (idx)
        REG_OPERATION: op = op_e'(data[1:0]);
        REG_ROWS_A:    rows_a = data;
        REG_COLS_A:    cols_a = data;
        REG_ROWS_B:    rows_b = data;
        REG_COLS_B:    cols_b = data;
        default: ;
      endcase
    endfunction

    // Size of the result matrix under the current operation
    function void result_shape(output logic [4:0] nr, output logic [4:0] nc);
      case (op)
        OP_MUL: begin
          nr = fit_dim(rows_a);
          nc = fit_dim(cols_b);
        end
        OP_TRN: begin
          nr = fit_dim(cols_a);
          nc = fit_dim(rows_a);
        end
        default: begin
          nr = fit_dim(rows_a);
          nc = fit_dim(cols_a);
        end
      endcase
    endfunction

    // Size mismatch wins over an index outside the result
    function logic [1:0] read_status(logic [3:0] r, logic [3:0] c);
      logic [4:0] nr;
      logic [4:0] nc;
      logic [1:0] st;
      st = ST_OK;
      result_shape(nr, nc);
      if (op == OP_ADD && (fit_dim(rows_a) != fit_dim(rows_b) ||
                           fit_dim(cols_a) != fit_dim(cols_b)))
        st = ST_DIM;
      if (op == OP_MUL && fit_dim(cols_a) != fit_dim(rows_b))
        st = ST_DIM;
      if (st == ST_OK && ({1'b0, r} >= nr || {1'b0, c} >= nc))
        st = ST_IDX;
      return st;
    endfunction

    function out_word_t predict_read(logic [3:0] r, logic [3:0] c);
      out_word_t   w;
      logic [31:0] acc;
      int          k;
      w.status = read_status(r, c);
      acc = '0;
      if (w.status == ST_OK) begin
        case (op)
          OP_ADD: acc = store_a[{r, c}] + store_b[{r, c}];
          OP_MUL: begin
            // Accumulate the dot product, wrapping at 32 bits
            for (k = 0; k < int'(fit_dim(cols_a)); k++)
              acc = acc + store_a[{r, 4'(k)}] * store_b[{4'(k), c}];
          end
          OP_NEG: acc = 32'd0 - store_a[{r, c}];
          default: acc = store_a[{c, r}];
        endcase
      end
      w.result_value = acc;
      return w;
    endfunction

    // Apply one accepted input word to the mirror
    function void note_word(in_word_t w);
      out_word_t want;
      case (w.command)
        CMD_WR_A: begin
          store_a[{w.row, w.col}]   = w.value;
          written_a[{w.row, w.col}] = 1'b1;
          words_in++;
        end
        CMD_WR_B: begin
          store_b[{w.row, w.col}]   = w.value;
          written_b[{w.row, w.col}] = 1'b1;
          words_in++;
        end
        CMD_READ: begin
          want = predict_read(w.row, w.col);
          if (want.status == ST_OK)
            reads_ok++;
          else
            reads_err++;
          pending_results.push_back(want);
          words_in++;
        end
        default: ;
      endcase
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("MISMATCH: %s", what);
    endfunction

    // Compare a popped result word against the oldest prediction
    function void check_result(out_word_t got);
      out_word_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d with none expected: value %h status %0d",
                         results_seen, got.result_value, got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.result_value !== want.result_value)
        report($sformatf("result %0d: expected value %h status %0d, got value %h status %0d",
                         results_seen, want.result_value, want.status,
                         got.result_value, got.status));
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

>>> tb/tb_matrix_arith_engine.sv
`timescale 1ns / 1ps
// Top-level testbench for matrix_arith_engine: drives writes, reads and register
// settings with random idling on both sides. Depends on mae_pkg and mae_tb_pkg.
module tb_matrix_arith_engine;
  import mae_pkg::*;
  import mae_tb_pkg::*;

  localparam logic [1:0]  CMD_NONE     = 2'd3;
  localparam int unsigned ITEMS        = 1500;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic       full;
  in_word_t   item      = '0;
  logic       empty;
  logic       pop       = 1'b0;
  out_word_t  result;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit          in_taken   = 1'b0;
  bit          idle_on    = 1'b1;
  int unsigned item_count = 0;
  int unsigned settings   = 0;
  engine_mirror mirror;

  matrix_arith_engine #(.MAX_DIM(DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Sample both handshakes and the register port at the rising edge
  always @(posedge clk) begin
    in_taken = push && !full;
    if (!rst) begin
      if (push && !full)
        mirror.note_word(item);
      if (pop && !empty)
        mirror.check_result(result);
      if (cfg_write)
        mirror.write_config(cfg_index, cfg_data);
    end
  end

  // Drain results, stalling in random bursts while idling is on
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        if (idle_on && $urandom_range(0, 99) < 6)
          stall_left = $urandom_range(1, 14);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sizes, with zero, full and oversized ones now and then
  function automatic logic [4:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 5'($urandom_range(1, 4));
    if (roll < 75) return 5'($urandom_range(5, 15));
    if (roll < 85) return 5'd16;
    if (roll < 92) return 5'd0;
    return 5'($urandom_range(17, 31));
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic push_word(logic [1:0] cmd, logic [3:0] r, logic [3:0] c, logic [31:0] v);
    in_word_t w;
    if (idle_on && $urandom_range(0, 99) < 10) begin
      push = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    w.command = cmd;
    w.row     = r;
    w.col     = c;
    w.value   = v;
    item = w;
    push = 1'b1;
    do @(negedge clk); while (!in_taken);
    if (cmd != CMD_NONE)
      item_count++;
  endtask

  // Wait until every result is back and the back end has gone quiet
  task automatic drain();
    push = 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
  endtask

  task automatic set_config(op_e o, logic [4:0] ra, logic [4:0] ca, logic [4:0] rb,
                            logic [4:0] cb);
    drain();
    write_reg(REG_OPERATION, {3'($urandom_range(0, 7)), o});
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_COLS_A, ca);
    write_reg(REG_ROWS_B, rb);
    write_reg(REG_COLS_B, cb);
    cfg_write = 1'b0;
    settings++;
  endtask

  task automatic fill(bit to_b, logic [3:0] r, logic [3:0] c);
    if (to_b ? !mirror.written_b[{r, c}] : !mirror.written_a[{r, c}])
      push_word(to_b ? CMD_WR_B : CMD_WR_A, r, c, pick_value());
  endtask

  // Write the entries the read will touch that are not yet written, then issue the read
  task automatic read_at(logic [3:0] r, logic [3:0] c);
    int k;
    if (mirror.read_status(r, c) == ST_OK) begin
      case (mirror.op)
        OP_ADD: begin
          fill(1'b0, r, c);
          fill(1'b1, r, c);
        end
        OP_MUL: begin
          for (k = 0; k < int'(mirror.fit_dim(mirror.cols_a)); k++) begin
            fill(1'b0, r, 4'(k));
            fill(1'b1, 4'(k), c);
          end
        end
        OP_NEG: fill(1'b0, r, c);
        default: fill(1'b0, c, r);
      endcase
    end
    push_word(CMD_READ, r, c, $urandom);
  endtask

  task automatic run_directed();
    // Wrapping add at the 1x1 reset size, then reads outside it
    push_word(CMD_WR_A, 4'd0, 4'd0, 32'h7fff_ffff);
    push_word(CMD_WR_B, 4'd0, 4'd0, 32'h0000_0001);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
    push_word(CMD_READ, 4'd0, 4'd1, 32'hffff_ffff);
    push_word(CMD_READ, 4'd15, 4'd15, 32'h0);
    push_word(CMD_NONE, 4'd15, 4'd15, 32'hffff_ffff);
    // Writes outside the configured size are kept
    push_word(CMD_WR_A, 4'd15, 4'd15, 32'h8000_0000);
    push_word(CMD_WR_B, 4'd15, 4'd15, 32'hffff_ffff);
    set_config(OP_NEG, 5'd1, 5'd1, 5'd1, 5'd1);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
    set_config(OP_ADD, 5'd16, 5'd16, 5'd16, 5'd16);
    push_word(CMD_READ, 4'd15, 4'd15, 32'h0);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
    // Oversized registers clamp to the full store
    set_config(OP_TRN, 5'd31, 5'd20, 5'd1, 5'd1);
    push_word(CMD_READ, 4'd15, 4'd15, 32'h0);
    // Size mismatch, also ahead of an index outside the result
    set_config(OP_ADD, 5'd2, 5'd2, 5'd1, 5'd2);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
    push_word(CMD_READ, 4'd15, 4'd15, 32'h0);
    set_config(OP_MUL, 5'd1, 5'd3, 5'd2, 5'd1);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
    // Empty matrices
    set_config(OP_MUL, 5'd0, 5'd1, 5'd1, 5'd1);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
    set_config(OP_NEG, 5'd1, 5'd0, 5'd1, 5'd1);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
    // Two-term product that wraps
    set_config(OP_MUL, 5'd1, 5'd2, 5'd2, 5'd1);
    push_word(CMD_WR_A, 4'd0, 4'd1, 32'hffff_fffe);
    push_word(CMD_WR_B, 4'd1, 4'd0, 32'h7fff_ffff);
    push_word(CMD_READ, 4'd0, 4'd0, 32'h0);
  endtask

  task automatic pick_setting(int p);
    op_e        o;
    logic [4:0] ra;
    logic [4:0] ca;
    logic [4:0] rb;
    logic [4:0] cb;
    case (p)
      0: set_config(OP_MUL, 5'd16, 5'd16, 5'd16, 5'd2);
      1: set_config(OP_ADD, 5'd31, 5'd31, 5'd16, 5'd16);
      2: set_config(OP_TRN, 5'd1, 5'd16, 5'd0, 5'd0);
      3: set_config(OP_NEG, 5'd16, 5'd1, 5'd31, 5'd0);
      4: set_config(OP_MUL, 5'd1, 5'd1, 5'd1, 5'd1);
      default: begin
        o  = op_e'($urandom_range(0, 3));
        ra = pick_size();
        ca = pick_size();
        rb = pick_size();
        cb = pick_size();
        // Keep most add and multiply settings compatible
        if ($urandom_range(0, 3) != 0) begin
          if (o == OP_ADD) begin
            rb = ra;
            cb = ca;
          end
          if (o == OP_MUL)
            rb = ca;
        end
        set_config(o, ra, ca, rb, cb);
      end
    endcase
  endtask

  task automatic random_word();
    int         roll;
    logic [4:0] nr;
    logic [4:0] nc;
    logic [3:0] r;
    logic [3:0] c;
    roll = $urandom_range(0, 99);
    mirror.result_shape(nr, nc);
    if (roll < 55) begin
      r = (nr == 0) ? 4'($urandom) : 4'($urandom_range(0, int'(nr) - 1));
      c = (nc == 0) ? 4'($urandom) : 4'($urandom_range(0, int'(nc) - 1));
      read_at(r, c);
    end else if (roll < 75) begin
      push_word(2'($urandom_range(0, 1)), 4'($urandom), 4'($urandom), pick_value());
    end else if (roll < 95) begin
      read_at(4'($urandom), 4'($urandom));
    end else begin
      push_word(CMD_NONE, 4'($urandom), 4'($urandom), $urandom);
    end
  endtask

  initial begin
    int p;
    mirror = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    p = 0;
    while (item_count < ITEMS) begin
      if (item_count > ITEMS - 250)
        idle_on = 1'b0;
      pick_setting(p);
      repeat ($urandom_range(30, 80))
        if (item_count < ITEMS)
          random_word();
      p++;
    end
    drain();
    $display("Covered %0d words in, %0d reads (%0d ok, %0d with error status), %0d results",
             mirror.words_in, mirror.reads_ok + mirror.reads_err, mirror.reads_ok,
             mirror.reads_err, mirror.results_seen);
    $display("over %0d register settings; %0d mismatches", settings, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", mirror.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
